FILE: rtl/core/char_lcd_init_refresh_sequencer_defines.svh
// Assertion macros shared by the LCD sequencer RTL.
`ifndef CHAR_LCD_INIT_REFRESH_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_INIT_REFRESH_SEQUENCER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CLCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("LCD sequencer assertion failed");
`define CLCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("LCD sequencer assertion failed");
`else
`define CLCD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CLCD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/clcd_seq_pkg.sv
package clcd_seq_pkg;

	localparam int ROWS    = 4;
	localparam int COLUMNS = 20;
	localparam int CELLS   = ROWS * COLUMNS;
	localparam int IDX_W   = $clog2(CELLS);
	localparam int WAIT_W  = 25;

	localparam logic [7:0] CMD_FUNCTION_SET = 8'h38;
	localparam logic [7:0] CMD_DISPLAY_OFF  = 8'h08;
	localparam logic [7:0] CMD_CLEAR        = 8'h01;
	localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
	localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;

	localparam logic [7:0] ROW_ADDR_0 = 8'h80;
	localparam logic [7:0] ROW_ADDR_1 = 8'hC0;
	localparam logic [7:0] ROW_ADDR_2 = 8'h94;
	localparam logic [7:0] ROW_ADDR_3 = 8'hD4;

	localparam logic [WAIT_W-1:0] WAIT_POWER_UP = WAIT_W'(1000000);
	localparam logic [WAIT_W-1:0] WAIT_FUNC_1   = WAIT_W'(500000);
	localparam logic [WAIT_W-1:0] WAIT_FUNC_2   = WAIT_W'(20000);
	localparam logic [WAIT_W-1:0] WAIT_OFF      = WAIT_W'(6000);
	localparam logic [WAIT_W-1:0] WAIT_CLEAR    = WAIT_W'(300000);
	localparam logic [WAIT_W-1:0] WAIT_ENTRY    = WAIT_W'(6000);
	localparam logic [WAIT_W-1:0] WAIT_ON       = WAIT_W'(20000);
	localparam logic [WAIT_W-1:0] WAIT_CHAR     = WAIT_W'(5000);
	localparam logic [WAIT_W-1:0] WAIT_LAST_ROW = WAIT_W'(11000);
	localparam logic [WAIT_W-1:0] WAIT_FRAME    = WAIT_W'(20000000);

	localparam logic [8*CELLS-1:0] LABEL_TEMPLATE = {
		"      Soll    Ist   ",
		" RPM:               ",
		"Volt:      V       V",
		"Temp:     Delay:    "
	};

	typedef struct packed {
		logic                strobe;
		logic [7:0]          cmd;
		logic [WAIT_W-1:0]   wait_units;
	} init_entry_t;

	function automatic logic [7:0] template_byte(input logic [IDX_W-1:0] idx);
		int unsigned sh;
		sh = 8 * (CELLS - 1 - int'(idx));
		return 8'(LABEL_TEMPLATE >> sh);
	endfunction

	function automatic logic [7:0] row_address(input logic [1:0] r);
		logic [7:0] a;
		unique case (r)
			2'd0: a = ROW_ADDR_0;
			2'd1: a = ROW_ADDR_1;
			2'd2: a = ROW_ADDR_2;
			default: a = ROW_ADDR_3;
		endcase
		return a;
	endfunction

	function automatic init_entry_t init_entry(input logic [2:0] s);
		init_entry_t e;
		unique case (s)
			3'd0: e = '{1'b0, 8'h00, WAIT_POWER_UP};
			3'd1: e = '{1'b1, CMD_FUNCTION_SET, WAIT_FUNC_1};
			3'd2: e = '{1'b1, CMD_FUNCTION_SET, WAIT_FUNC_2};
			3'd3: e = '{1'b1, CMD_DISPLAY_OFF, WAIT_OFF};
			3'd4: e = '{1'b1, CMD_CLEAR, WAIT_CLEAR};
			3'd5: e = '{1'b1, CMD_ENTRY_MODE, WAIT_ENTRY};
			3'd6: e = '{1'b1, CMD_DISPLAY_ON, WAIT_ON};
			default: e = '0;
		endcase
		return e;
	endfunction

endpackage

FILE: rtl/core/char_lcd_init_refresh_sequencer.sv
// Character LCD sequencer for a 4x20 panel. Every tick beat on the input
// (tuser 0) yields exactly one output beat with the bus byte, the register
// select, the strobe flag and the wait before the next tick; a write beat
// (tuser 1) stores a character in the 80-entry display buffer, if its column
// is below 20, and yields nothing. One beat is accepted per cycle unless the
// input stalls. The synchronous buffer read happens at the edge that accepts
// a tick, into the read stage, and the output register is loaded from the
// read stage once it is empty or being drained. When the output is held off,
// the read stage and the output register fill and the input stalls until the
// output drains. After reset the buffer reads as the label template, with no
// clearing pass; per-entry valid bits select the template until an entry
// has been written.
module char_lcd_init_refresh_sequencer
	import clcd_seq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // row[1:0], column[6:2], character[14:7], zero fill
	input  logic        s_tuser,  // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // bus_byte[7:0], wait_units[32:8], zero fill
	output logic [1:0]  m_tuser   // strobe_res[0], register_select[1]
);

	logic [1:0]  in_row;
	logic [4:0]  in_col;
	logic [7:0]  in_char;
	logic        accept, tick_acc, wr_acc, advance;

	assign in_row  = s_tdata[1:0];
	assign in_col  = s_tdata[6:2];
	assign in_char = s_tdata[14:7];
	assign accept   = s_tvalid && s_tready;
	assign tick_acc = accept && !s_tuser;
	assign wr_acc   = accept && s_tuser;

	// Sequencer state.
	logic        init_q;
	logic [2:0]  step_q;
	logic [1:0]  cur_row_q;
	logic [4:0]  cur_col_q;

	logic        nx_init;
	logic [2:0]  nx_step;
	logic [1:0]  nx_row;
	logic [4:0]  nx_col;
	logic        t_strobe, t_rs, t_use_buf;
	logic [7:0]  t_byte;
	logic [WAIT_W-1:0] t_wait;
	logic [6:0]  rd_idx;
	logic        rd_inrange;
	init_entry_t ie;

	assign rd_idx     = 7'(cur_row_q * 7'(COLUMNS)) + 7'(cur_col_q);
	assign rd_inrange = rd_idx < 7'(CELLS);
	assign ie         = init_entry(step_q);

	always_comb begin
		nx_init   = init_q;
		nx_step   = step_q;
		nx_row    = cur_row_q;
		nx_col    = cur_col_q;
		t_strobe  = 1'b0;
		t_rs      = 1'b0;
		t_use_buf = 1'b0;
		t_byte    = 8'h00;
		t_wait    = '0;
		if (!init_q) begin
			t_strobe = ie.strobe;
			t_byte   = ie.cmd;
			t_wait   = ie.wait_units;
			if (step_q == 3'd6) begin
				nx_init = 1'b1;
				nx_step = 3'd0;
			end else if (step_q != 3'd7) begin
				nx_step = step_q + 3'd1;
			end
		end else if (!step_q[0]) begin
			t_strobe = 1'b1;
			t_byte   = row_address(step_q[2:1]);
			t_wait   = WAIT_CHAR;
			nx_step  = step_q + 3'd1;
		end else begin
			t_strobe  = 1'b1;
			t_rs      = 1'b1;
			t_use_buf = 1'b1;
			if (cur_col_q >= 5'(COLUMNS - 1)) begin
				nx_col = '0;
				if (step_q == 3'd7) begin
					nx_row  = '0;
					nx_step = 3'd0;
					t_wait  = WAIT_FRAME;
				end else begin
					nx_row  = step_q[2:1] + 2'd1;
					nx_step = step_q + 3'd1;
					t_wait  = WAIT_CHAR;
				end
			end else begin
				nx_col = cur_col_q + 5'd1;
				t_wait = (step_q == 3'd7) ? WAIT_LAST_ROW : WAIT_CHAR;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q    <= 1'b0;
			step_q    <= '0;
			cur_row_q <= '0;
			cur_col_q <= '0;
		end else if (tick_acc) begin
			init_q    <= nx_init;
			step_q    <= nx_step;
			cur_row_q <= nx_row;
			cur_col_q <= nx_col;
		end
	end

	// Display buffer and its valid bits.
	logic [7:0]       mem [CELLS];
	logic [CELLS-1:0] wvalid_q;
	logic [6:0]       wr_idx;
	logic             wr_en, rd_en;

	assign wr_idx = 7'(in_row * 7'(COLUMNS)) + 7'(in_col);
	assign wr_en  = wr_acc && (in_col < 5'(COLUMNS));
	assign rd_en  = tick_acc && t_use_buf && rd_inrange;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx[IDX_W-1:0]] <= in_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvalid_q <= '0;
		end else if (wr_en) begin
			wvalid_q[wr_idx[IDX_W-1:0]] <= 1'b1;
		end
	end

	// Stage 1: buffer read in flight.
	logic              valid_s1, strobe_s1, rs_s1, use_buf_s1, inrange_s1, memv_s1;
	logic [7:0]        byte_s1, tmpl_s1, rdata_s1, byte_fin;
	logic [WAIT_W-1:0] wait_s1;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= mem[rd_idx[IDX_W-1:0]];
			memv_s1  <= wvalid_q[rd_idx[IDX_W-1:0]];
			tmpl_s1  <= template_byte(rd_idx[IDX_W-1:0]);
		end
		if (tick_acc) begin
			strobe_s1  <= t_strobe;
			rs_s1      <= t_rs;
			use_buf_s1 <= t_use_buf;
			inrange_s1 <= rd_inrange;
			byte_s1    <= t_byte;
			wait_s1    <= t_wait;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_comb begin
		if (!use_buf_s1) begin
			byte_fin = byte_s1;
		end else if (!inrange_s1) begin
			byte_fin = 8'h00;
		end else if (memv_s1) begin
			byte_fin = rdata_s1;
		end else begin
			byte_fin = tmpl_s1;
		end
	end

	// Output register.
	logic        out_valid_q;
	logic [39:0] out_data_q;
	logic [1:0]  out_user_q;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {7'd0, wait_s1, byte_fin};
			out_user_q <= {rs_s1, strobe_s1};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

`include "char_lcd_init_refresh_sequencer_defines.svh"

	`CLCD_ASSERT_NOW(a_col_range, clk, arst_n, 1'b1, cur_col_q < 5'(COLUMNS))
	`CLCD_ASSERT_NOW(a_init_step, clk, arst_n, !init_q, step_q != 3'd7)
	`CLCD_ASSERT_NOW(a_col_odd_step, clk, arst_n, init_q && cur_col_q != 5'd0, step_q[0])
	`CLCD_ASSERT_NOW(a_stall_blocks, clk, arst_n, valid_s1 && !advance, !s_tready)
	`CLCD_ASSERT_NEXT(a_tick_fills, clk, arst_n, tick_acc, valid_s1)

endmodule
